// ===== sv/ets_pkg.sv =====
`default_nettype none

package ets_pkg;

  localparam int BEST_W = 12;
  localparam logic [BEST_W-1:0] BOUND_INIT = 12'd3000;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CITY = 1'b1;
  localparam logic [3:0] CITY_COUNT_RESET = 4'd5;
  localparam logic [2:0] START_CITY_RESET = 3'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_EVAL,
    ST_STEP,
    ST_SW_A,
    ST_SW_B,
    ST_SW_W1,
    ST_SW_W2
  } state_t;

  localparam state_t ST_DONE_ALIAS = ST_IDLE;

endpackage

`default_nettype wire

// ===== sv/ets_ram.sv =====
`default_nettype none

module ets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/exhaustive_tour_min_search.sv =====
// Exhaustive tour minimum search. Load the distance matrix with write beats
// (tuser = 0), one entry per beat; entries whose row or col
// is not below MAX_CITIES are dropped. A start beat (tuser = 1) walks every
// ordering of the cities with start_city fixed first, sums each closed tour
// including the return edge, and returns one beat holding the smallest sum,
// capped at 3000 (the cap restarts on every start beat). Every matrix entry a
// search touches must have been written first. The matrix sits in one RAM of
// MAX_CITIES*MAX_CITIES words and the current tour order in a second RAM of
// MAX_CITIES words; both have a registered read, so tour evaluation streams
// one edge per cycle through two read stages. A search first lays out the
// tour order (identity with start_city swapped into place 0), then sums one
// tour, takes control steps that climb the counter stack, and swaps two tour
// positions in the order RAM (read one, read the other, write both back)
// before every later tour, with one final step ending the search. Input is
// held off from a start beat until the result is handed to the output
// register; write beats and configuration writes are taken while a result
// still waits for m_axis_tready.
`default_nettype none

module exhaustive_tour_min_search
  import ets_pkg::*;
#(
  parameter int MAX_CITIES = 8,
  parameter int DIST_BITS  = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,  // row[2:0], col[5:3], distance[15:6]
  input  wire logic [0:0]            s_axis_tuser,  // op[0]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [15:0]           m_axis_tdata   // least_distance[11:0], zero fill
);

  localparam int IDX_W  = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int TAB_D  = MAX_CITIES * MAX_CITIES;
  localparam int TAB_AW = $clog2(TAB_D);
  localparam int SUM_W  = DIST_BITS + $clog2(MAX_CITIES + 1);
  localparam int CMP_W  = (SUM_W > BEST_W) ? SUM_W : BEST_W;
  localparam logic [TAB_AW-1:0] TAB_STRIDE = TAB_AW'(MAX_CITIES);
  localparam logic [IDX_W-1:0]  LAST_POS   = IDX_W'(MAX_CITIES - 1);
  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_CITIES);

  // Configuration registers
  logic [3:0] city_count;
  logic [2:0] start_city;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RESET;
      start_city <= START_CITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CITY_COUNT: city_count <= cfg_data[3:0];
        CFG_START_CITY: start_city <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Input beat fields
  logic                 in_op;
  logic [2:0]           in_row;
  logic [2:0]           in_col;
  logic [9:0]           in_dist;
  logic                 in_beat;

  assign in_op   = s_axis_tuser[0];
  assign in_row  = s_axis_tdata[2:0];
  assign in_col  = s_axis_tdata[5:3];
  assign in_dist = s_axis_tdata[15:6];
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // Effective city count clamped to the supported range; an out-of-range start city becomes 0
  logic [CNT_W-1:0] n_req;
  logic [IDX_W-1:0] s_req;

  always_comb begin
    if (city_count < 4'd2) begin
      n_req = CNT_W'(2);
    end else if (CNT_W'(city_count) > MAX_CNT || {1'b0, city_count} > 5'(MAX_CITIES)) begin
      n_req = MAX_CNT;
    end else begin
      n_req = CNT_W'(city_count);
    end
    if (4'(start_city) < 4'(n_req) && CNT_W'(start_city) < n_req) begin
      s_req = IDX_W'(start_city);
    end else begin
      s_req = '0;
    end
  end

  // Search state
  state_t           state, state_next;
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] s_eff;
  logic [IDX_W-1:0] init_pos;
  logic [IDX_W-1:0] lvl;               // current level of the counter stack
  logic [IDX_W-1:0] stack [MAX_CITIES];
  logic [IDX_W-1:0] sw_a, sw_b;        // tour positions being swapped
  logic [IDX_W-1:0] sw_hold;
  logic [BEST_W-1:0] best;

  // Tour-sum pipeline
  logic [CNT_W-1:0] iss;               // issue slot; slot n-1 is the return edge
  logic             issuing;
  logic             v1, close1;        // tour word back from the order RAM
  logic             v2, close2;        // distance word back from the table RAM
  logic [IDX_W-1:0] prev_city;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic             sum_better;
  logic             eval_done;

  // RAM ports
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  logic [DIST_BITS-1:0] tab_wdata, tab_rdata;
  logic              ord_we;
  logic [IDX_W-1:0]  ord_waddr, ord_raddr, ord_wdata, ord_rdata;

  // Control
  logic step_done, step_swap, init_last, out_free;

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign init_last  = (init_pos == LAST_POS);
  assign step_done  = (CNT_W'(lvl) >= n_eff - CNT_W'(1));
  assign step_swap  = (stack[lvl] < lvl);

  assign sum_next   = sum + SUM_W'(tab_rdata);
  assign sum_better = CMP_W'(sum_next) < CMP_W'(best);
  assign eval_done  = (state == ST_EVAL) && v2 && close2;

  ets_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (TAB_D)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  ets_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_CITIES)
  ) u_order (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Table writes come only from write beats; drop entries outside the matrix
  assign tab_we    = in_beat && (in_op == OP_WRITE) &&
                     (4'(in_row) < 4'(MAX_CITIES) || MAX_CITIES > 8) &&
                     (4'(in_col) < 4'(MAX_CITIES) || MAX_CITIES > 8);
  assign tab_waddr = TAB_AW'(in_row) * TAB_STRIDE + TAB_AW'(in_col);
  assign tab_wdata = DIST_BITS'(in_dist);

  // Stage one forms the edge address: previous city to the fetched one, or
  // back to the start city on the closing slot
  assign tab_raddr = TAB_AW'(prev_city) * TAB_STRIDE +
                     TAB_AW'(close1 ? s_eff : ord_rdata);

  // Order RAM port steering and next state
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ord_we        = 1'b0;
    ord_waddr     = init_pos;
    ord_wdata     = init_pos;
    ord_raddr     = IDX_W'(iss + CNT_W'(1));
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_beat && in_op == OP_START) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        // identity order with the start city swapped into place 0
        ord_we    = 1'b1;
        ord_waddr = init_pos;
        if (init_pos == '0) begin
          ord_wdata = s_eff;
        end else if (init_pos == s_eff) begin
          ord_wdata = '0;
        end else begin
          ord_wdata = init_pos;
        end
        if (init_last) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_done) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else if (step_swap) begin
          state_next = ST_SW_A;
        end
      end
      ST_SW_A: begin
        ord_raddr  = sw_a;
        state_next = ST_SW_B;
      end
      ST_SW_B: begin
        ord_raddr  = sw_b;
        state_next = ST_SW_W1;
      end
      ST_SW_W1: begin
        ord_we     = 1'b1;
        ord_waddr  = sw_a;
        ord_wdata  = ord_rdata;
        state_next = ST_SW_W2;
      end
      ST_SW_W2: begin
        ord_we     = 1'b1;
        ord_waddr  = sw_b;
        ord_wdata  = sw_hold;
        state_next = ST_EVAL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      best    <= BOUND_INIT;
      lvl     <= '0;
      for (int k = 0; k < MAX_CITIES; k++) begin
        stack[k] <= '0;
      end
    end else begin
      // sum pipeline advances every cycle
      v1     <= issuing;
      close1 <= (iss == n_eff - CNT_W'(1));
      v2     <= v1;
      close2 <= close1;
      if (v1 && !close1) begin
        prev_city <= ord_rdata;
      end
      if (v2) begin
        sum <= sum_next;
      end
      if (issuing) begin
        iss <= iss + CNT_W'(1);
        if (iss == n_eff - CNT_W'(1)) begin
          issuing <= 1'b0;
        end
      end
      if (eval_done && sum_better) begin
        best <= BEST_W'(sum_next);
      end

      case (state)
        ST_IDLE: begin
          if (in_beat && in_op == OP_START) begin
            n_eff    <= n_req;
            s_eff    <= s_req;
            init_pos <= '0;
            lvl      <= '0;
            best     <= BOUND_INIT;
            for (int k = 0; k < MAX_CITIES; k++) begin
              stack[k] <= '0;
            end
          end
        end
        ST_INIT: begin
          init_pos <= init_pos + IDX_W'(1);
          if (init_last) begin
            issuing   <= 1'b1;
            iss       <= '0;
            sum       <= '0;
            prev_city <= s_eff;
          end
        end
        ST_STEP: begin
          if (!step_done) begin
            if (step_swap) begin
              sw_a       <= lvl[0] ? stack[lvl] + IDX_W'(1) : IDX_W'(1);
              sw_b       <= lvl + IDX_W'(1);
              stack[lvl] <= stack[lvl] + IDX_W'(1);
              lvl        <= '0;
            end else begin
              stack[lvl] <= '0;
              lvl        <= lvl + IDX_W'(1);
            end
          end
        end
        ST_SW_B: begin
          sw_hold <= ord_rdata;
        end
        ST_SW_W2: begin
          issuing   <= 1'b1;
          iss       <= '0;
          sum       <= '0;
          prev_city <= s_eff;
        end
        default: ;
      endcase
    end
  end

  // Result register: load when the search ends and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_STEP && step_done && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= 16'(best);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
